// ----- rtl/debounced_digit_matrix_display_top_defines.svh -----
// ----------------------------------------------------------------------------
// Debounced digit matrix display: assertion macros
// Shared assertion forms for the display block. Each macro expands to one
// labeled concurrent assertion with reset disable and an error report.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_DIGIT_MATRIX_DISPLAY_TOP_DEFINES_SVH
`define DEBOUNCED_DIGIT_MATRIX_DISPLAY_TOP_DEFINES_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds.
`define DMD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent holds in the next cycle.
`define DMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Debounced digit matrix display package
// Types, constants and the 5x5 glyph table shared by the display modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dmd_pkg;

	// Matrix geometry.
	localparam int DMD_PIXEL_COUNT = 25;
	localparam int DMD_IDX_W       = $clog2(DMD_PIXEL_COUNT);

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_WINDOW = 3'd0,
		REG_RED    = 3'd1,
		REG_GREEN  = 3'd2,
		REG_BLUE   = 3'd3,
		REG_GAIN   = 3'd4
	} dmd_reg_t;

	// Reset values of the configuration registers.
	localparam logic [31:0] DMD_WINDOW_RST = 32'd200000;
	localparam logic [7:0]  DMD_RED_RST    = 8'd0;
	localparam logic [7:0]  DMD_GREEN_RST  = 8'd0;
	localparam logic [7:0]  DMD_BLUE_RST   = 8'd1;
	localparam logic [7:0]  DMD_GAIN_RST   = 8'd100;

	// Digit limits; the blank display is minus one.
	localparam logic signed [4:0] DMD_DIGIT_BLANK = -5'sd1;
	localparam logic signed [4:0] DMD_DIGIT_MIN   = 5'sd0;
	localparam logic signed [4:0] DMD_DIGIT_MAX   = 5'sd9;

	// Commands.
	localparam logic CMD_UP   = 1'b0;
	localparam logic CMD_DOWN = 1'b1;

	// One pixel held in a cell of the shift chain.
	typedef struct packed {
		logic                 vld;
		logic                 lit;
		logic [DMD_IDX_W-1:0] idx;
	} dmd_px_t;

	// Status from the chain to the press logic.
	typedef struct packed {
		logic free;
	} dmd_chain_st_t;

	// Lit-pixel mask of a digit; bit i is pixel i of the chain. Anything
	// outside 0..9 (the blank digit) lights nothing.
	function automatic logic [DMD_PIXEL_COUNT-1:0] glyph_mask(input logic signed [4:0] digit);
		logic [DMD_PIXEL_COUNT-1:0] m;
		case (digit)
			5'sd0:   m = 25'h0E5294E;
			5'sd1:   m = 25'h043108E;
			5'sd2:   m = 25'h0E4384E;
			5'sd3:   m = 25'h0E4390E;
			5'sd4:   m = 25'h0A53902;
			5'sd5:   m = 25'h0E1390E;
			5'sd6:   m = 25'h0E1394E;
			5'sd7:   m = 25'h0E40902;
			5'sd8:   m = 25'h0E5394E;
			5'sd9:   m = 25'h0E5390E;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/dmd_cell.sv -----
// ----------------------------------------------------------------------------
// Display chain cell
// Holds one pixel of a frame. Loads a fresh pixel when a frame starts and
// otherwise takes its upper neighbor's pixel on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module dmd_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire logic            shift,
	input  wire dmd_pkg::dmd_px_t load_px,
	input  wire dmd_pkg::dmd_px_t next_px,
	output dmd_pkg::dmd_px_t      px
);
	import dmd_pkg::*;

	dmd_px_t px_q;

	// Load has priority; a load only happens when the chain is draining anyway.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
		end else if (load) begin
			px_q <= load_px;
		end else if (shift) begin
			px_q <= next_px;
		end
	end

	assign px = px_q;

endmodule

`default_nettype wire

// ----- rtl/dmd_chain.sv -----
// ----------------------------------------------------------------------------
// Display pixel chain
// A row of pixel cells. A frame is loaded in parallel from a glyph mask and
// shifts to the head cell, which presents one pixel per cycle when not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dmd_chain (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                load,
	input  wire logic [dmd_pkg::DMD_PIXEL_COUNT-1:0] mask,
	input  wire logic                                out_ready,
	output dmd_pkg::dmd_px_t                         head,
	output dmd_pkg::dmd_chain_st_t                   st
);
	import dmd_pkg::*;

	dmd_px_t px [DMD_PIXEL_COUNT];
	logic    shift;

	// The chain moves whenever the head is empty or its item is taken.
	assign shift    = !px[0].vld || out_ready;
	// A new frame may enter when the chain will be empty after this shift.
	assign st.free  = shift && !px[1].vld;
	assign head     = px[0];

	for (genvar i = 0; i < DMD_PIXEL_COUNT; i++) begin : g_cell
		dmd_px_t load_px;
		dmd_px_t next_px;

		assign load_px.vld = 1'b1;
		assign load_px.lit = mask[i];
		assign load_px.idx = DMD_IDX_W'(i);

		if (i == DMD_PIXEL_COUNT - 1) begin : g_tail
			assign next_px = '0;
		end else begin : g_body
			assign next_px = px[i+1];
		end

		dmd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (load),
			.shift   (shift),
			.load_px (load_px),
			.next_px (next_px),
			.px      (px[i])
		);
	end

endmodule

`default_nettype wire

// ----- rtl/debounced_digit_matrix_display_top.sv -----
// ----------------------------------------------------------------------------
// Debounced digit matrix display
// Debounces up/down button presses, steps a saturating digit and streams the
// digit's 5x5 glyph as 25 pixel words.
// ----------------------------------------------------------------------------
// A press is registered in an input stage and judged there: it counts only
// if the wrapping 32-bit time since the last counted press exceeds the
// debounce window, otherwise it is dropped without waiting for the chain.
// A counted press steps the digit and loads a row of 25 pixel cells in
// parallel; the row then shifts one pixel word to the output per cycle while
// out_ready is high. The next frame loads in the cycle the last word of the
// previous frame is taken, so frames follow with no gap, and a new press is
// accepted into the input stage while a frame is still streaming.
// Configuration writes are always accepted and must only be issued while the
// block is idle.
`default_nettype none

`include "debounced_digit_matrix_display_top_defines.svh"

module debounced_digit_matrix_display_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// Press input channel.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [31:0] event_time_us,
	// Pixel output channel.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      pixel_word,
	output logic [4:0]       pixel_index,
	output logic signed [4:0] shown_digit,
	output logic             last_pixel
);
	import dmd_pkg::*;

	// Configuration registers.
	logic [31:0] window_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic [7:0]  gain_q;

	// Press state.
	logic [31:0]       last_time_q;
	logic signed [4:0] digit_q;
	logic [31:0]       color_q;

	// Input stage.
	logic        vld_s1;
	logic        cmd_s1;
	logic [31:0] time_s1;

	logic [31:0]                elapsed;
	logic                       pass;
	logic                       go_s1;
	logic                       load;
	logic signed [4:0]          digit_nxt;
	logic [15:0]                prod_r;
	logic [15:0]                prod_g;
	logic [15:0]                prod_b;
	logic [31:0]                color_nxt;
	logic [DMD_PIXEL_COUNT-1:0] mask;
	dmd_px_t                    head;
	dmd_chain_st_t              st;

	// Register writes; unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= DMD_WINDOW_RST;
			red_q    <= DMD_RED_RST;
			green_q  <= DMD_GREEN_RST;
			blue_q   <= DMD_BLUE_RST;
			gain_q   <= DMD_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW: window_q <= cfg_data;
				REG_RED:    red_q    <= cfg_data[7:0];
				REG_GREEN:  green_q  <= cfg_data[7:0];
				REG_BLUE:   blue_q   <= cfg_data[7:0];
				REG_GAIN:   gain_q   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Debounce check on the registered press.
	assign elapsed = time_s1 - last_time_q;
	assign pass    = elapsed > window_q;
	// A rejected press leaves at once; a counted one waits for a free chain.
	assign go_s1    = vld_s1 && (!pass || st.free);
	assign load     = vld_s1 && pass && st.free;
	assign in_ready = !vld_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= command;
			time_s1 <= event_time_us;
		end
	end

	// Saturating digit step.
	always_comb begin
		digit_nxt = digit_q;
		if (cmd_s1 == CMD_UP) begin
			if (digit_q < DMD_DIGIT_MAX) begin
				digit_nxt = digit_q + 5'sd1;
			end
		end else begin
			if (digit_q > DMD_DIGIT_MIN) begin
				digit_nxt = digit_q - 5'sd1;
			end
		end
	end

	// Scaled color, each channel kept modulo 256.
	assign prod_r    = red_q * gain_q;
	assign prod_g    = green_q * gain_q;
	assign prod_b    = blue_q * gain_q;
	assign color_nxt = {prod_b[7:0], prod_r[7:0], prod_g[7:0], 8'h00};
	assign mask      = glyph_mask(digit_nxt);

	// State updated by a counted press.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			digit_q     <= DMD_DIGIT_BLANK;
		end else if (load) begin
			last_time_q <= time_s1;
			digit_q     <= digit_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			color_q <= color_nxt;
		end
	end

	dmd_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.mask      (mask),
		.out_ready (out_ready),
		.head      (head),
		.st        (st)
	);

	// Output item from the head cell.
	assign out_valid   = head.vld;
	assign pixel_word  = head.lit ? color_q : 32'd0;
	assign pixel_index = head.idx;
	assign shown_digit = digit_q;
	assign last_pixel  = head.idx == DMD_IDX_W'(DMD_PIXEL_COUNT - 1);

	// A loaded frame starts at pixel zero on the next cycle.
	`DMD_ASSERT_NEXT(a_load_starts_frame, clk, arst_n, load,
		out_valid && (pixel_index == 5'd0), "frame did not start at pixel zero")
	// A frame streams without gaps until its last pixel.
	`DMD_ASSERT_NEXT(a_frame_contiguous, clk, arst_n,
		out_valid && out_ready && !last_pixel, out_valid, "gap inside a frame")
	// A rejected press leaves the debounce time alone.
	`DMD_ASSERT_NEXT(a_reject_keeps_time, clk, arst_n, vld_s1 && !pass,
		$stable(last_time_q), "rejected press changed the last press time")
	// The shown digit stays between blank and nine.
	`DMD_ASSERT_NOW(a_digit_range, clk, arst_n, out_valid,
		(digit_q >= DMD_DIGIT_BLANK) && (digit_q <= DMD_DIGIT_MAX), "digit out of range")

endmodule

`default_nettype wire

// ----- tb/digit_frame_check_pkg.sv -----
// ----------------------------------------------------------------------------
// Digit frame checker
// Holds a cycle-free model of the debounced digit display: the debounce
// window, the color registers, the last counted press and the shown digit.
// Each accepted press that clears the window queues one expected frame of
// pixel words, and each pixel word that leaves the block is compared with
// the oldest queued word.
// ----------------------------------------------------------------------------
`default_nettype none

package digit_frame_check_pkg;

	import dmd_pkg::*;

	// Register indexes the block does not decode; writes to them are ignored.
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

	// Only the first few mismatches are printed in full.
	localparam int REPORT_LIMIT = 10;

	// One pixel word as it leaves the block.
	typedef struct packed {
		logic [31:0] word;
		logic [4:0]  index;
		logic [4:0]  digit;
		logic        last;
	} pixel_item_t;

	class frame_scoreboard;

		logic [31:0]       window_us;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [7:0]        gain;
		logic [31:0]       last_press_us;
		logic signed [4:0] digit;
		pixel_item_t       frame_q[$];
		int                errors;

		// Start from the state the block has after reset.
		function new();
			window_us     = DMD_WINDOW_RST;
			red           = DMD_RED_RST;
			green         = DMD_GREEN_RST;
			blue          = DMD_BLUE_RST;
			gain          = DMD_GAIN_RST;
			last_press_us = '0;
			digit         = DMD_DIGIT_BLANK;
			errors        = 0;
		endfunction

		// Apply one register write; color registers keep their low byte.
		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_WINDOW: window_us = data;
				REG_RED:    red       = data[7:0];
				REG_GREEN:  green     = data[7:0];
				REG_BLUE:   blue      = data[7:0];
				REG_GAIN:   gain      = data[7:0];
				default:    ;
			endcase
		endfunction

		// Lit pixels of each digit in chain order; the blank digit lights none.
		function logic [DMD_PIXEL_COUNT-1:0] lit_pixels(logic signed [4:0] d);
			logic [DMD_PIXEL_COUNT-1:0] m;
			case (d)
				5'sd0:   m = 25'h0E5294E;
				5'sd1:   m = 25'h043108E;
				5'sd2:   m = 25'h0E4384E;
				5'sd3:   m = 25'h0E4390E;
				5'sd4:   m = 25'h0A53902;
				5'sd5:   m = 25'h0E1390E;
				5'sd6:   m = 25'h0E1394E;
				5'sd7:   m = 25'h0E40902;
				5'sd8:   m = 25'h0E5394E;
				5'sd9:   m = 25'h0E5390E;
				default: m = '0;
			endcase
			return m;
		endfunction

		// Judge one press and, if it counts, queue the frame it causes.
		function void note_press(logic cmd, logic [31:0] t_us);
			logic [31:0]                elapsed;
			logic [7:0]                 rr;
			logic [7:0]                 gg;
			logic [7:0]                 bb;
			logic [31:0]                color;
			logic [DMD_PIXEL_COUNT-1:0] lit;
			pixel_item_t                px;
			elapsed = t_us - last_press_us;
			if (elapsed <= window_us)
				return;
			last_press_us = t_us;

			// The digit saturates at both ends; blank only leaves on an up press.
			if (cmd == CMD_UP) begin
				if (digit < DMD_DIGIT_MAX)
					digit = digit + 5'sd1;
			end else begin
				if (digit > DMD_DIGIT_MIN)
					digit = digit - 5'sd1;
			end

			// Each channel is its level times the gain, modulo 256.
			rr    = red * gain;
			gg    = green * gain;
			bb    = blue * gain;
			color = {bb, rr, gg, 8'h00};
			lit   = lit_pixels(digit);

			for (int i = 0; i < DMD_PIXEL_COUNT; i++) begin
				px.word  = lit[i] ? color : 32'h0;
				px.index = 5'(i);
				px.digit = digit;
				px.last  = (i == DMD_PIXEL_COUNT - 1);
				frame_q.push_back(px);
			end
		endfunction

		// Count a failure and print it while under the report limit.
		function void flag(string msg);
			if (errors < REPORT_LIMIT)
				$display("ERROR: %s", msg);
			errors++;
		endfunction

		// Compare one pixel word from the block with the oldest expected word.
		function void check_pixel(pixel_item_t got);
			pixel_item_t want;
			if (frame_q.size() == 0) begin
				flag($sformatf("unexpected pixel word=%h index=%0d digit=%0d last=%b",
					got.word, got.index, $signed(got.digit), got.last));
				return;
			end
			want = frame_q.pop_front();
			if (got.word !== want.word || got.index !== want.index ||
					got.digit !== want.digit || got.last !== want.last)
				flag($sformatf({"pixel mismatch: expected word=%h index=%0d digit=%0d last=%b,",
					" got word=%h index=%0d digit=%0d last=%b"},
					want.word, want.index, $signed(want.digit), want.last,
					got.word, got.index, $signed(got.digit), got.last));
		endfunction

		function int pending();
			return frame_q.size();
		endfunction

		// Words still queued at the end never arrived.
		function void close_out();
			if (frame_q.size() != 0)
				flag($sformatf("%0d expected pixel words never arrived", frame_q.size()));
		endfunction

	endclass

endpackage

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Debounced digit matrix display testbench
// Drives button presses and register writes into the display block with
// random idle gaps on the press side and random stalls on the pixel side.
// A scoreboard predicts every frame and checks each pixel word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import dmd_pkg::*;
	import digit_frame_check_pkg::*;

	localparam int RUN_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 40;
	localparam int PHASES        = 8;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index     = '0;
	logic [31:0]       cfg_data      = '0;
	logic              in_valid      = 1'b0;
	logic              in_ready;
	logic              command       = CMD_UP;
	logic [31:0]       event_time_us = '0;
	logic              out_valid;
	logic              out_ready     = 1'b0;
	logic [31:0]       pixel_word;
	logic [4:0]        pixel_index;
	logic signed [4:0] shown_digit;
	logic              last_pixel;

	frame_scoreboard   sb = new();

	// Stimulus-side view of the debounce, used only to shape the press times.
	logic [31:0]       anchor_us  = '0;
	logic [31:0]       cur_window = DMD_WINDOW_RST;
	logic              quiet_phase = 1'b0;
	logic              ready_free  = 1'b0;
	int                ready_hold  = 0;
	int                ready_roll;
	int unsigned       cycle_count;
	pixel_item_t       seen_px;

	debounced_digit_matrix_display_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.event_time_us (event_time_us),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_word    (pixel_word),
		.pixel_index   (pixel_index),
		.shown_digit   (shown_digit),
		.last_pixel    (last_pixel)
	);

	// Free-running clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Pixel side: runs of ready, short stalls and the odd long stall.
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_free || ready_roll < 60) begin
				out_ready  <= 1'b1;
				ready_hold <= $urandom_range(0, 7);
			end else if (ready_roll < 93) begin
				out_ready  <= 1'b0;
				ready_hold <= $urandom_range(0, 2);
			end else begin
				out_ready  <= 1'b0;
				ready_hold <= $urandom_range(5, 20);
			end
		end
	end

	// Watch all three channels and feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_press(command, event_time_us);
			if (out_valid && out_ready) begin
				seen_px.word  = pixel_word;
				seen_px.index = pixel_index;
				seen_px.digit = shown_digit;
				seen_px.last  = last_pixel;
				sb.check_pixel(seen_px);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Idle cycles before a press: mostly none, some short, a few long.
	function automatic int press_gap();
		int r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Offer one press item and hold it until the block takes it.
	task automatic send_press(input logic cmd, input logic [31:0] t_us, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		event_time_us <= t_us;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if ((t_us - anchor_us) > cur_window)
			anchor_us = t_us;
	endtask

	// Offer one register write and hold it until the block takes it.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_WINDOW)
			cur_window = data;
	endtask

	// Let every queued frame drain and the input stage go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          phase;
		int          presses;
		int          roll;
		logic [31:0] t_us;
		logic [31:0] win;
		logic [32:0] reach;
		logic [7:0]  lvl_r;
		logic [7:0]  lvl_g;
		logic [7:0]  lvl_b;
		logic [7:0]  lvl_k;
		logic        dir;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset configuration.
		// A press right after reset is measured from time zero and bounces.
		send_press(CMD_UP, 32'h0, press_gap());
		// Exactly the window since the last counted press still bounces.
		t_us = DMD_WINDOW_RST;
		send_press(CMD_DOWN, t_us, press_gap());
		// One past the window counts; a down press while blank sends a blank frame.
		t_us = DMD_WINDOW_RST + 32'd1;
		send_press(CMD_DOWN, t_us, press_gap());
		// Walk up to nine and press once more at the top, with a jump to the
		// last timestamp and a press just after the timer wraps.
		for (int i = 0; i < 11; i++) begin
			t_us = (i == 5) ? 32'hFFFF_FFFF : t_us + DMD_WINDOW_RST + 32'd1;
			send_press(CMD_UP, t_us, press_gap());
		end
		// A bounce in the middle of the frame stream.
		send_press(CMD_DOWN, t_us + 32'd100, press_gap());
		// Walk down to zero and press once more at the bottom.
		for (int i = 0; i < 10; i++) begin
			t_us = t_us + DMD_WINDOW_RST + 32'd1;
			send_press(CMD_DOWN, t_us, press_gap());
		end

		// Random phases, each with its own register setting.
		dir = CMD_UP;
		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			lvl_r = $urandom();
			lvl_g = $urandom();
			lvl_b = $urandom();
			lvl_k = $urandom();
			case (phase)
				0: begin
					win   = 32'h0;
					lvl_r = 8'hFF;
					lvl_g = 8'hFF;
					lvl_b = 8'hFF;
					lvl_k = 8'hFF;
				end
				1: begin
					win   = 32'hFFFF_FFFF;
					lvl_r = 8'h00;
					lvl_g = 8'h00;
					lvl_b = 8'h00;
					lvl_k = 8'h00;
				end
				2: win = $urandom_range(1, 1000);
				3: begin
					win   = DMD_WINDOW_RST;
					lvl_k = 8'h01;
				end
				4: win = $urandom();
				5: win = $urandom_range(0, 5000);
				6: win = 32'hFFFF_FFFE;
				default: win = $urandom_range(0, 300000);
			endcase
			write_reg(REG_WINDOW, win);
			write_reg(REG_RED, {24'($urandom()), lvl_r});
			write_reg(REG_GREEN, {24'($urandom()), lvl_g});
			write_reg(REG_BLUE, {24'($urandom()), lvl_b});
			write_reg(REG_GAIN, {24'($urandom()), lvl_k});
			write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
			cfg_valid   <= 1'b0;
			quiet_phase = ($urandom_range(0, 3) == 0);
			ready_free  = ($urandom_range(0, 4) == 0);

			// A window that rejects everything needs only a short phase.
			presses = (phase == 1) ? 20 : 50;
			for (int n = 0; n < presses; n++) begin
				// Mostly runs in one direction so the digit reaches both ends.
				if ($urandom_range(0, 7) == 0)
					dir = ~dir;
				roll  = $urandom_range(0, 99);
				reach = {1'b0, cur_window} + 33'd1;
				if (roll < 60)
					reach = reach + 33'($urandom_range(0, 500));
				if (roll < 70)
					t_us = anchor_us + (reach[32] ? 32'hFFFF_FFFF : reach[31:0]);
				else if (roll < 78)
					t_us = anchor_us + cur_window;
				else if (roll < 92)
					t_us = anchor_us + 32'($urandom_range(0, cur_window));
				else
					t_us = $urandom();
				send_press(($urandom_range(0, 9) < 8) ? dir : ~dir, t_us, press_gap());
			end
		end

		// Drain the last frames, then watch for stray words.
		in_valid    <= 1'b0;
		quiet_phase = 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/dmd_pkg.sv
rtl/dmd_cell.sv
rtl/dmd_chain.sv
rtl/debounced_digit_matrix_display_top.sv
tb/digit_frame_check_pkg.sv
tb/testbench.sv
